>>> rtl/lfpo_pkg.sv
`timescale 1ns / 1ps

package lfpo_pkg;

	localparam int CMD_FRAC = 32;
	localparam int POS_W = 16;
	localparam int CMD_W = 16 + CMD_FRAC;
	localparam int UP_SHIFT = (CMD_FRAC >= 32) ? CMD_FRAC - 32 : 0;
	localparam int DOWN_SHIFT = (CMD_FRAC < 32) ? 32 - CMD_FRAC : 0;
	localparam int CORR_W = 54;
	localparam int SUM_W = CORR_W + UP_SHIFT + 1;
	localparam int QDEPTH = 2;

	localparam logic signed [CMD_W-1:0] CMD_MAX = {1'b0, {(CMD_W-1){1'b1}}};
	localparam logic signed [CMD_W-1:0] CMD_MIN = {1'b1, {(CMD_W-1){1'b0}}};

	localparam logic [1:0] OP_FRAME = 2'd0;
	localparam logic [1:0] OP_RENC  = 2'd1;
	localparam logic [1:0] OP_LENC  = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	localparam logic [2:0] CFG_KP          = 3'd0;
	localparam logic [2:0] CFG_KI          = 3'd1;
	localparam logic [2:0] CFG_SPEED_REF   = 3'd2;
	localparam logic [2:0] CFG_SPEED_CEIL  = 3'd3;
	localparam logic [2:0] CFG_CORNER_THR  = 3'd4;
	localparam logic [2:0] CFG_LOST_THR    = 3'd5;
	localparam logic [2:0] CFG_LOST_FRAMES = 3'd6;

	typedef struct packed {
		logic [1:0] op;
		logic [9:0] sensor_0;
		logic [9:0] sensor_1;
		logic [9:0] sensor_2;
		logic [9:0] sensor_3;
		logic [9:0] sensor_4;
		logic [7:0] timer_now;
		logic       enc_xor;
		logic       enc_b;
	} in_t;

	typedef struct packed {
		logic [7:0]         right_speed;
		logic [7:0]         left_speed;
		logic [1:0]         advance_requests;
		logic [2:0]         right_turns;
		logic               go_home;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [1:0]         heading;
		logic signed [15:0] distance_count;
	} out_t;

	typedef struct packed {
		logic [31:0] kp_gain;
		logic [31:0] ki_tick_gain;
		logic [7:0]  base_speed;
		logic [7:0]  speed_ceiling;
		logic [9:0]  corner_threshold;
		logic [9:0]  lost_threshold;
		logic [7:0]  lost_frames;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [4:0][9:0]    sens;
		logic signed [10:0] err;
		logic [7:0]         timer;
		logic               enc_xor;
		logic               enc_b;
	} item_t;

	function automatic logic signed [15:0] pos_to_out(input logic [POS_W-1:0] v);
		logic signed [31:0] w;
		w = 32'(signed'(v));
		return w[15:0];
	endfunction

endpackage

>>> rtl/lfpo_front.sv
`timescale 1ns / 1ps

module lfpo_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  lfpo_pkg::in_t   in_data,
	output logic            push_valid,
	input  logic            push_ready,
	output lfpo_pkg::item_t push_data
);
	import lfpo_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	item_t item_d;

	// Decode the word and form the steering error up front.
	always_comb begin
		item_d.sens = {in_data.sensor_4, in_data.sensor_3, in_data.sensor_2,
			in_data.sensor_1, in_data.sensor_0};
		item_d.err = signed'({1'b0, in_data.sensor_1}) - signed'({1'b0, in_data.sensor_3});
		item_d.timer = in_data.timer_now;
		item_d.enc_xor = in_data.enc_xor;
		item_d.enc_b = in_data.enc_b;
		unique case (in_data.op)
			OP_FRAME: item_d.kind = OP_FRAME;
			OP_RENC:  item_d.kind = OP_RENC;
			OP_LENC:  item_d.kind = OP_LENC;
			OP_NONE:  item_d.kind = OP_NONE;
		endcase
	end

	assign in_ready = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_data = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_d;
		end
	end

endmodule

>>> rtl/lfpo_queue.sv
`timescale 1ns / 1ps

module lfpo_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  lfpo_pkg::item_t push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output lfpo_pkg::item_t pop_data
);
	import lfpo_pkg::*;

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	item_t           mem_q [QDEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            push_ok;
	logic            pop_ok;

	assign push_ready = (count_q != CW'(QDEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data = mem_q[rd_ptr_q];
	assign push_ok = push_valid && push_ready;
	assign pop_ok = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push_ok, pop_ok})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QDEPTH))
		else $error("queue count beyond depth");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> wr_ptr_q == rd_ptr_q)
		else $error("empty queue with pointers apart");

endmodule

>>> rtl/lfpo_back.sv
`timescale 1ns / 1ps

module lfpo_back (
	input  logic            clk,
	input  logic            arst_n,
	input  lfpo_pkg::cfg_t  cfg,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  lfpo_pkg::item_t pop_data,
	output logic            out_valid,
	input  logic            out_ready,
	output lfpo_pkg::out_t  out_data
);
	import lfpo_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL2 = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]               state_q;
	item_t                    item_q;

	logic signed [44:0]       p1_s1;
	logic signed [43:0]       p2_s1;
	logic [7:0]               dt_s1;
	logic signed [52:0]       p3_s2;
	logic signed [CMD_W-1:0]  cmd_s3;

	logic signed [10:0]       last_err_q;
	logic signed [CMD_W-1:0]  last_cmd_q;
	logic [7:0]               last_timer_q;
	logic [7:0]               lost_run_q;
	logic [1:0]               heading_q;
	logic [POS_W-1:0]         x_q;
	logic [POS_W-1:0]         y_q;
	logic                     rpa_q;
	logic                     rpb_q;
	logic                     lpa_q;
	logic                     lpb_q;
	logic [15:0]              steps_q;

	logic                     out_valid_q;
	out_t                     out_q;

	logic                     pop;
	logic                     load;
	logic signed [11:0]       diff;
	logic signed [44:0]       p1;
	logic signed [43:0]       p2;
	logic signed [52:0]       p3;
	logic signed [CORR_W-1:0] corr;
	logic signed [SUM_W-1:0]  corr_sh;
	logic signed [SUM_W-1:0]  sum;
	logic signed [CMD_W-1:0]  cmd;

	logic [15:0]              ip;
	logic signed [16:0]       ci;
	logic signed [17:0]       r_raw;
	logic signed [17:0]       l_raw;
	logic                     rc;
	logic                     lc;
	logic [1:0]               h1;
	logic                     lost;
	logic [7:0]               run_inc;
	logic                     trig;
	logic                     enc_a;
	logic                     fwd;
	logic                     bwd;
	logic [POS_W-1:0]         step;

	out_t                     res;
	logic [1:0]               heading_n;
	logic [7:0]               lost_run_n;
	logic [POS_W-1:0]         x_n;
	logic [POS_W-1:0]         y_n;
	logic [15:0]              steps_n;

	assign pop_ready = (state_q == ST_IDLE);
	assign pop = pop_valid && pop_ready;
	assign load = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// First products come straight from the queue head.
	always_comb begin
		diff = {pop_data.err[10], pop_data.err} - {last_err_q[10], last_err_q};
		p1 = $signed({1'b0, cfg.kp_gain}) * diff;
		p2 = $signed({1'b0, cfg.ki_tick_gain}) * last_err_q;
	end

	assign p3 = p2_s1 * $signed({1'b0, dt_s1});

	// Align the correction to the command format, accumulate and saturate.
	always_comb begin
		corr = CORR_W'(p1_s1) + CORR_W'(p3_s2);
		corr_sh = (SUM_W'(corr) <<< UP_SHIFT) >>> DOWN_SHIFT;
		sum = corr_sh + SUM_W'(last_cmd_q);
		if (sum > SUM_W'(CMD_MAX)) begin
			cmd = CMD_MAX;
		end else if (sum < SUM_W'(CMD_MIN)) begin
			cmd = CMD_MIN;
		end else begin
			cmd = sum[CMD_W-1:0];
		end
	end

	always_comb begin
		res = '0;
		heading_n = heading_q;
		lost_run_n = lost_run_q;
		x_n = x_q;
		y_n = y_q;
		steps_n = steps_q;

		// The integer part rounds toward zero, so negative values with a fraction move up one.
		ip = cmd_s3[CMD_W-1:CMD_FRAC];
		ci = {ip[15], ip} + {16'd0, cmd_s3[CMD_W-1] && (|cmd_s3[CMD_FRAC-1:0])};
		r_raw = {10'd0, cfg.base_speed} + {ci[16], ci};
		l_raw = {10'd0, cfg.base_speed} - {ci[16], ci};

		rc = item_q.sens[4] > cfg.corner_threshold;
		lc = item_q.sens[0] > cfg.corner_threshold;
		h1 = heading_q + {1'b0, rc} + {2{lc}};
		lost = 1'b1;
		for (int i = 0; i < 5; i++) begin
			if (item_q.sens[i] >= cfg.lost_threshold) begin
				lost = 1'b0;
			end
		end
		run_inc = lost_run_q + 8'd1;
		trig = lost && (run_inc == cfg.lost_frames);

		enc_a = item_q.enc_xor ^ item_q.enc_b;
		fwd = (item_q.enc_b == rpa_q);
		bwd = (enc_a == rpb_q);
		step = fwd ? POS_W'(1) : '1;

		unique case (item_q.kind)
			OP_FRAME: begin
				if (r_raw[17]) begin
					res.right_speed = 8'd0;
				end else if (r_raw > {10'd0, cfg.speed_ceiling}) begin
					res.right_speed = cfg.speed_ceiling;
				end else begin
					res.right_speed = r_raw[7:0];
				end
				if (l_raw[17]) begin
					res.left_speed = 8'd0;
				end else if (l_raw > {10'd0, cfg.speed_ceiling}) begin
					res.left_speed = cfg.speed_ceiling;
				end else begin
					res.left_speed = l_raw[7:0];
				end
				res.advance_requests = {1'b0, rc} + {1'b0, lc};
				res.right_turns = {2'b0, rc} + (trig ? {1'b0, 2'(2'd0 - h1)} : 3'd0);
				res.go_home = trig;
				heading_n = trig ? 2'd0 : h1;
				lost_run_n = (lost && !trig) ? run_inc : 8'd0;
			end
			OP_RENC: begin
				// Forward and backward on the same edge cancel out.
				if (fwd ^ bwd) begin
					unique case (heading_q)
						2'd0: x_n = x_q + step;
						2'd1: y_n = y_q + step;
						2'd2: x_n = x_q - step;
						2'd3: y_n = y_q - step;
					endcase
				end
			end
			OP_LENC: begin
				steps_n = steps_q + {15'd0, item_q.enc_b == lpa_q}
					- {15'd0, enc_a == lpb_q};
			end
			OP_NONE: begin
			end
		endcase

		res.pos_x = pos_to_out(x_n);
		res.pos_y = pos_to_out(y_n);
		res.heading = heading_n;
		res.distance_count = steps_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			last_err_q <= '0;
			last_cmd_q <= '0;
			last_timer_q <= '0;
			lost_run_q <= '0;
			heading_q <= '0;
			x_q <= '0;
			y_q <= '0;
			rpa_q <= 1'b0;
			rpb_q <= 1'b0;
			lpa_q <= 1'b0;
			lpb_q <= 1'b0;
			steps_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= (pop_data.kind == OP_FRAME) ? ST_MUL2 : ST_FIN;
					end
				end
				ST_MUL2: state_q <= ST_SAT;
				ST_SAT:  state_q <= ST_FIN;
				ST_FIN: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
			endcase

			if (load) begin
				out_valid_q <= 1'b1;
				heading_q <= heading_n;
				lost_run_q <= lost_run_n;
				x_q <= x_n;
				y_q <= y_n;
				steps_q <= steps_n;
				unique case (item_q.kind)
					OP_FRAME: begin
						last_err_q <= item_q.err;
						last_cmd_q <= cmd_s3;
						last_timer_q <= item_q.timer;
					end
					OP_RENC: begin
						rpa_q <= enc_a;
						rpb_q <= item_q.enc_b;
					end
					OP_LENC: begin
						lpa_q <= enc_a;
						lpb_q <= item_q.enc_b;
					end
					OP_NONE: begin
					end
				endcase
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= pop_data;
			p1_s1 <= p1;
			p2_s1 <= p2;
			dt_s1 <= pop_data.timer - last_timer_q;
		end
		if (state_q == ST_MUL2) begin
			p3_s2 <= p3;
		end
		if (state_q == ST_SAT) begin
			cmd_s3 <= cmd;
		end
		if (load) begin
			out_q <= res;
		end
	end

	a_request_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.right_turns <= 3'd4 && out_q.advance_requests <= 2'd2))
		else $error("turn or advance request out of range");

	a_home_heading: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.go_home |-> out_q.heading == 2'd0)
		else $error("return home without heading reset");

	a_encoder_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		load && item_q.kind != OP_FRAME |=>
		out_q.right_speed == 8'd0 && out_q.left_speed == 8'd0 &&
		out_q.right_turns == 3'd0 && !out_q.go_home)
		else $error("non-frame word produced motor requests");

endmodule

>>> rtl/line_follow_pi_odometry.sv
`timescale 1ns / 1ps

// Line follower controller with incremental PI steering and quadrature odometry.
// Each accepted word gives exactly one result word, in order. In the back end a
// sensor frame goes through the first pair of gain multiplies as it leaves the
// queue, the multiply by the timer difference, the saturating command
// accumulate, then the speed clamp and state write-back, each step registered;
// encoder edges and the unused opcode go straight to the write-back. The back end
// handles one word at a time, while an input register and a two-entry queue let
// the input side keep accepting during that work and while a result waits on
// out_ready. Configuration writes are always accepted (cfg_ready stays high)
// and must only be issued while the block is idle; indexes beyond the register
// list are ignored.
module line_follow_pi_odometry (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  lfpo_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output lfpo_pkg::out_t out_data,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [2:0]     cfg_index,
	input  logic [31:0]    cfg_data
);
	import lfpo_pkg::*;

	cfg_t  cfg_q;
	logic  push_valid;
	logic  push_ready;
	item_t push_data;
	logic  pop_valid;
	logic  pop_ready;
	item_t pop_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp_gain <= 32'd42949673;
			cfg_q.ki_tick_gain <= 32'd21475;
			cfg_q.base_speed <= 8'd20;
			cfg_q.speed_ceiling <= 8'd20;
			cfg_q.corner_threshold <= 10'd500;
			cfg_q.lost_threshold <= 10'd100;
			cfg_q.lost_frames <= 8'd10;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_KP:          cfg_q.kp_gain <= cfg_data;
				CFG_KI:          cfg_q.ki_tick_gain <= cfg_data;
				CFG_SPEED_REF:   cfg_q.base_speed <= cfg_data[7:0];
				CFG_SPEED_CEIL:  cfg_q.speed_ceiling <= cfg_data[7:0];
				CFG_CORNER_THR:  cfg_q.corner_threshold <= cfg_data[9:0];
				CFG_LOST_THR:    cfg_q.lost_threshold <= cfg_data[9:0];
				CFG_LOST_FRAMES: cfg_q.lost_frames <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	lfpo_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	lfpo_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	lfpo_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

>>> test/line_follow_pi_odometry_test.sv
`timescale 1ns / 1ps

module line_follow_pi_odometry_test;
	import lfpo_pkg::*;

	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 12;
	localparam logic [2:0] CFG_UNUSED = 3'd7;

	localparam cfg_t RESET_SETTING = '{
		kp_gain: 32'd42949673,
		ki_tick_gain: 32'd21475,
		base_speed: 8'd20,
		speed_ceiling: 8'd20,
		corner_threshold: 10'd500,
		lost_threshold: 10'd100,
		lost_frames: 8'd10
	};

	typedef enum int {LEVEL_ANY, LEVEL_DARK, LEVEL_CORNER, LEVEL_RAIL} level_e;

	// Tracks the controller state on its own and holds the words it expects back.
	class course_tracker;
		cfg_t cfg;
		logic signed [10:0] prev_error;
		logic signed [CMD_W-1:0] command;
		logic [7:0] prev_timer;
		logic [7:0] lost_run;
		logic [1:0] heading;
		logic [POS_W-1:0] x_pos;
		logic [POS_W-1:0] y_pos;
		logic r_prev_a, r_prev_b, l_prev_a, l_prev_b;
		logic [15:0] left_count;
		out_t predicted_outputs[$];
		int mismatches;

		function new();
			cfg = RESET_SETTING;
			prev_error = '0;
			command = '0;
			prev_timer = '0;
			lost_run = '0;
			heading = '0;
			x_pos = '0;
			y_pos = '0;
			r_prev_a = 1'b0;
			r_prev_b = 1'b0;
			l_prev_a = 1'b0;
			l_prev_b = 1'b0;
			left_count = '0;
			mismatches = 0;
		endfunction

		function void set_register(logic [2:0] index, logic [31:0] value);
			case (index)
				CFG_KP:          cfg.kp_gain = value;
				CFG_KI:          cfg.ki_tick_gain = value;
				CFG_SPEED_REF:   cfg.base_speed = value[7:0];
				CFG_SPEED_CEIL:  cfg.speed_ceiling = value[7:0];
				CFG_CORNER_THR:  cfg.corner_threshold = value[9:0];
				CFG_LOST_THR:    cfg.lost_threshold = value[9:0];
				CFG_LOST_FRAMES: cfg.lost_frames = value[7:0];
				default: ;
			endcase
		endfunction

		function void step_position(bit forward);
			logic [POS_W-1:0] d;
			d = forward ? POS_W'(1) : '1;
			case (heading)
				2'd0: x_pos = x_pos + d;
				2'd1: y_pos = y_pos + d;
				2'd2: x_pos = x_pos - d;
				default: y_pos = y_pos - d;
			endcase
		endfunction

		function void accept_word(in_t w);
			out_t r;
			logic [9:0] s [5];
			bit lost;
			int e;
			logic [7:0] dt;
			logic [1:0] back;
			logic a, b;
			longint corr, cmd, whole, rs, ls;
			r = '0;
			case (w.op)
				OP_FRAME: begin
					s = '{w.sensor_0, w.sensor_1, w.sensor_2, w.sensor_3, w.sensor_4};
					lost = 1'b1;
					foreach (s[k]) if (s[k] >= cfg.lost_threshold) lost = 1'b0;
					// Right corner is taken before left when both show in one frame.
					if (s[4] > cfg.corner_threshold) begin
						r.advance_requests += 2'd1;
						r.right_turns += 3'd1;
						heading = heading + 2'd1;
					end
					if (s[0] > cfg.corner_threshold) begin
						r.advance_requests += 2'd1;
						heading = heading - 2'd1;
					end
					if (lost) begin
						lost_run = lost_run + 8'd1;
						if (lost_run == cfg.lost_frames) begin
							back = 2'd0 - heading;
							r.right_turns += 3'(back);
							heading = 2'd0;
							r.go_home = 1'b1;
							lost_run = '0;
						end
					end else begin
						lost_run = '0;
					end
					e = int'(s[1]) - int'(s[3]);
					dt = w.timer_now - prev_timer;
					corr = longint'(cfg.kp_gain) * longint'(e - int'(prev_error))
						+ longint'(cfg.ki_tick_gain) * longint'(prev_error) * longint'(dt);
					if (DOWN_SHIFT > 0) corr = corr >>> DOWN_SHIFT;
					else corr = corr <<< UP_SHIFT;
					cmd = longint'(command) + corr;
					if (cmd > longint'(CMD_MAX)) cmd = longint'(CMD_MAX);
					if (cmd < longint'(CMD_MIN)) cmd = longint'(CMD_MIN);
					whole = (cmd >= 0) ? (cmd >>> CMD_FRAC) : -((-cmd) >>> CMD_FRAC);
					rs = longint'(cfg.base_speed) + whole;
					ls = longint'(cfg.base_speed) - whole;
					if (rs > longint'(cfg.speed_ceiling)) rs = longint'(cfg.speed_ceiling);
					if (ls > longint'(cfg.speed_ceiling)) ls = longint'(cfg.speed_ceiling);
					if (rs < 0) rs = 0;
					if (ls < 0) ls = 0;
					r.right_speed = 8'(rs);
					r.left_speed = 8'(ls);
					prev_timer = w.timer_now;
					prev_error = 11'(e);
					command = CMD_W'(cmd);
				end
				OP_RENC: begin
					b = w.enc_b;
					a = w.enc_xor ^ b;
					// Both tests may hold on one edge; the two steps then cancel.
					if (b == r_prev_a) step_position(1'b1);
					if (a == r_prev_b) step_position(1'b0);
					r_prev_a = a;
					r_prev_b = b;
				end
				OP_LENC: begin
					b = w.enc_b;
					a = w.enc_xor ^ b;
					if (a == l_prev_b) left_count = left_count - 16'd1;
					if (b == l_prev_a) left_count = left_count + 16'd1;
					l_prev_a = a;
					l_prev_b = b;
				end
				default: ;
			endcase
			r.pos_x = 16'(signed'(x_pos));
			r.pos_y = 16'(signed'(y_pos));
			r.heading = heading;
			r.distance_count = left_count;
			predicted_outputs.push_back(r);
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (got === want) return;
			mismatches++;
			if (mismatches <= 10)
				$display("%s mismatch: expected %h, got %h", name, want, got);
		endfunction

		function void check_word(out_t got);
			out_t want;
			if (predicted_outputs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("result word %h arrived with nothing pending", got);
				return;
			end
			want = predicted_outputs.pop_front();
			compare_field("right_speed", want.right_speed, got.right_speed);
			compare_field("left_speed", want.left_speed, got.left_speed);
			compare_field("advance_requests", want.advance_requests, got.advance_requests);
			compare_field("right_turns", want.right_turns, got.right_turns);
			compare_field("go_home", want.go_home, got.go_home);
			compare_field("pos_x", want.pos_x, got.pos_x);
			compare_field("pos_y", want.pos_y, got.pos_y);
			compare_field("heading", want.heading, got.heading);
			compare_field("distance_count", want.distance_count, got.distance_count);
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	course_tracker tracker = new();
	bit calm = 1'b0;
	bit hold_request = 1'b0;
	int lost_left = 0;
	logic [7:0] timer_clock = '0;
	logic [1:0] right_phase = '0;
	logic [1:0] left_phase = '0;

	line_follow_pi_odometry dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic level_e random_level();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5) return LEVEL_ANY;
		if (r < 7) return LEVEL_DARK;
		if (r < 9) return LEVEL_CORNER;
		return LEVEL_RAIL;
	endfunction

	function automatic logic [9:0] pick_sensor(level_e kind);
		int lt, ct;
		lt = tracker.cfg.lost_threshold;
		ct = tracker.cfg.corner_threshold;
		case (kind)
			LEVEL_ANY:    return 10'($urandom_range(0, 1000));
			LEVEL_DARK:   return (lt == 0) ? 10'd0 : 10'($urandom_range(0, lt - 1));
			LEVEL_CORNER: return (ct >= 1000) ? 10'd1000 : 10'($urandom_range(ct + 1, 1000));
			default:      return $urandom_range(0, 1) ? 10'd1000 : 10'd0;
		endcase
	endfunction

	function automatic in_t make_frame(bit dark);
		in_t w;
		logic [9:0] s [5];
		w = '0;
		foreach (s[k]) s[k] = dark ? pick_sensor(LEVEL_DARK) : pick_sensor(random_level());
		w.op = OP_FRAME;
		w.sensor_0 = s[0];
		w.sensor_1 = s[1];
		w.sensor_2 = s[2];
		w.sensor_3 = s[3];
		w.sensor_4 = s[4];
		// Mostly small timer steps, now and then a jump that may wrap.
		timer_clock = timer_clock + 8'(($urandom_range(0, 9) == 0) ?
			$urandom_range(0, 255) : $urandom_range(0, 12));
		w.timer_now = timer_clock;
		w.enc_xor = 1'($urandom);
		w.enc_b = 1'($urandom);
		return w;
	endfunction

	// Encoder words walk the quadrature cycle, with some pauses and jumps.
	function automatic in_t make_step(logic [1:0] op);
		in_t w;
		logic [1:0] p;
		int r;
		w = '0;
		w.op = op;
		p = (op == OP_RENC) ? right_phase : left_phase;
		r = $urandom_range(0, 19);
		if (r < 11) p = p + 2'd1;
		else if (r < 17) p = p - 2'd1;
		else if (r == 19) p = 2'($urandom);
		w.enc_xor = p[0];
		w.enc_b = p[1] ^ p[0];
		if (op == OP_RENC) right_phase = p;
		else left_phase = p;
		return w;
	endfunction

	function automatic in_t random_word();
		in_t w;
		int r, lf;
		r = $urandom_range(0, 99);
		lf = tracker.cfg.lost_frames;
		if (r < 55) begin
			if (lost_left == 0 && $urandom_range(0, 24) == 0)
				lost_left = (lf == 0) ? 270 : $urandom_range((lf > 3) ? lf - 2 : 1, lf + 3);
			if (lost_left > 0) begin
				lost_left--;
				w = make_frame(1'b1);
			end else begin
				w = make_frame(1'b0);
			end
		end else if (r < 75) begin
			w = make_step(OP_RENC);
		end else if (r < 95) begin
			w = make_step(OP_LENC);
		end else begin
			w = make_frame(1'b0);
			w.op = OP_NONE;
		end
		return w;
	endfunction

	function automatic in_t sensor_frame(int s0, int s1, int s2, int s3, int s4, int t);
		in_t w;
		w = '0;
		w.op = OP_FRAME;
		w.sensor_0 = 10'(s0);
		w.sensor_1 = 10'(s1);
		w.sensor_2 = 10'(s2);
		w.sensor_3 = 10'(s3);
		w.sensor_4 = 10'(s4);
		w.timer_now = 8'(t);
		return w;
	endfunction

	function automatic in_t encoder_word(logic [1:0] op, logic x, logic b);
		in_t w;
		w = '0;
		w.op = op;
		w.enc_xor = x;
		w.enc_b = b;
		return w;
	endfunction

	task automatic push_word(in_t w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		tracker.accept_word(w);
	endtask

	task automatic cfg_write(logic [2:0] index, logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_register(index, value);
	endtask

	task automatic drain();
		while (tracker.predicted_outputs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_setting(int phase);
		cfg_t s;
		case (phase)
			0: s = RESET_SETTING;
			1: begin
				s = '0;
				s.lost_frames = 8'd1;
			end
			2: s = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255, 8'd255, 10'd1000, 10'd1000, 8'd255};
			3: s = '{$urandom >> 2, $urandom >> 12, 8'd128, 8'd200, 10'd700, 10'd200, 8'd3};
			4: s = '{32'h8000_0000, 32'd0, 8'd255, 8'd100, 10'd300, 10'd50, 8'd1};
			// A lost-frame limit of zero only fires after a full wrap of the counter.
			5: s = '{$urandom >> 8, $urandom >> 16, 8'd60, 8'd120, 10'd1000, 10'd1000, 8'd0};
			default: s = '{$urandom, $urandom, 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 10'($urandom_range(0, 1000)),
				10'($urandom_range(0, 1000)), 8'($urandom_range(1, 255))};
		endcase
		cfg_write(CFG_KP, s.kp_gain);
		cfg_write(CFG_KI, s.ki_tick_gain);
		cfg_write(CFG_SPEED_REF, 32'(s.base_speed));
		cfg_write(CFG_SPEED_CEIL, 32'(s.speed_ceiling));
		cfg_write(CFG_CORNER_THR, 32'(s.corner_threshold));
		cfg_write(CFG_LOST_THR, 32'(s.lost_threshold));
		cfg_write(CFG_LOST_FRAMES, 32'(s.lost_frames));
		if (phase == 6) cfg_write(CFG_UNUSED, $urandom);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_random(int count, bit press);
		lost_left = (tracker.cfg.lost_frames == 0) ? 270 : 0;
		for (int i = 0; i < count; i++) begin
			calm = (i < 40);
			// The sink holds off while the source keeps offering back to back.
			if (press && i == 5) hold_request = 1'b1;
			push_word(random_word());
		end
		calm = 1'b0;
		in_valid <= 1'b0;
	endtask

	initial begin : result_sink
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				tracker.check_word(out_data);
				if (stall == 0) stall = pick_gap();
			end else if (stall == 0 && $urandom_range(0, 15) == 0) begin
				stall = pick_gap();
			end
			if (hold_request) begin
				stall = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : stimulus
		int phase_items [7];
		phase_items = '{250, 200, 250, 250, 200, 500, 250};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words run on the reset settings.
		push_word(sensor_frame(0, 0, 0, 0, 0, 0));
		push_word(sensor_frame(1000, 1000, 1000, 1000, 1000, 200));
		push_word(sensor_frame(500, 100, 100, 100, 500, 205));
		push_word(sensor_frame(500, 500, 500, 500, 1000, 210));
		push_word(sensor_frame(1000, 500, 500, 500, 500, 220));
		push_word(sensor_frame(0, 1000, 0, 0, 1000, 250));
		push_word(sensor_frame(0, 0, 0, 1000, 0, 4));
		push_word(sensor_frame(600, 1000, 0, 0, 600, 255));
		for (int v = 0; v < 4; v++) push_word(encoder_word(OP_RENC, v[1], v[0]));
		for (int v = 0; v < 4; v++) push_word(encoder_word(OP_LENC, v[1], v[0]));
		push_word('{OP_NONE, 10'd1000, 10'd1000, 10'd1000, 10'd1000, 10'd1000,
			8'd255, 1'b1, 1'b1});
		// A run of dark frames reaches the lost limit and turns back to heading 0.
		for (int n = 0; n < 10; n++) push_word(sensor_frame(99, 99, 99, 99, 99, 10 + n));
		in_valid <= 1'b0;
		drain();

		for (int p = 0; p < 7; p++) begin
			apply_setting(p);
			run_random(phase_items[p], p == 3);
			drain();
		end

		if (tracker.mismatches == 0 && tracker.predicted_outputs.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
